// ----- src/tle_pkg.sv -----
package tle_pkg;

  localparam int TIME_BITS = 32;
  localparam int FRAC_BITS = 16;
  localparam int CFG_W     = 16;
  localparam int LAT_W     = 31;
  localparam int LON_W     = 32;
  localparam int ALT_W     = 18;
  localparam int POS_W     = 32;

  localparam logic [CFG_W-1:0] MAX_EXT_RESET = CFG_W'(10000);

  // quotient = min(since, limit) * 2^FRAC_BITS / delta
  localparam int QUOT_W     = CFG_W + FRAC_BITS;
  localparam int DIV_CNT_W  = $clog2(QUOT_W);
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(QUOT_W - 1);

  localparam int MAG_W  = POS_W;
  localparam int PROD_W = MAG_W + QUOT_W;
  localparam int RND_W  = PROD_W - FRAC_BITS + 1;

  localparam int STEP_CLAMP_LOG = 40;
  localparam int STEP_W         = STEP_CLAMP_LOG + 1;
  localparam logic [STEP_W-1:0] STEP_CLAMP = {1'b1, {STEP_CLAMP_LOG{1'b0}}};

  localparam int SUM_W = STEP_W + 1;

  localparam logic signed [SUM_W-1:0] LAT_MIN = SUM_W'(-900000000);
  localparam logic signed [SUM_W-1:0] LAT_MAX = SUM_W'(900000000);
  localparam logic signed [SUM_W-1:0] LON_MIN = SUM_W'(-1800000000);
  localparam logic signed [SUM_W-1:0] LON_MAX = SUM_W'(1800000000);
  localparam logic signed [SUM_W-1:0] ALT_MIN = SUM_W'(-2000);
  localparam logic signed [SUM_W-1:0] ALT_MAX = SUM_W'(100000);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_DIFF,
    ST_MUL,
    ST_STEP,
    ST_ADD,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    COMP_LAT,
    COMP_LON,
    COMP_ALT
  } comp_t;

  typedef struct packed {
    logic  accept;
    logic  prep;
    logic  div_step;
    logic  diff;
    logic  mul;
    logic  step;
    logic  add;
    logic  out_load;
    comp_t comp;
  } ctrl_cmd_t;

  typedef struct packed {
    logic proj_ok;
    logic out_busy;
  } dp_status_t;

endpackage

// ----- src/tle_cfg_if.sv -----
interface tle_cfg_if import tle_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- src/tle_in_if.sv -----
interface tle_in_if import tle_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [TIME_BITS-1:0]    sample_time_ms;
  logic signed [LAT_W-1:0] latitude;
  logic signed [LON_W-1:0] longitude;
  logic signed [ALT_W-1:0] altitude_ft;

  modport source (output valid, output sample_time_ms, output latitude,
                  output longitude, output altitude_ft, input ready);
  modport sink (input valid, input sample_time_ms, input latitude,
                input longitude, input altitude_ft, output ready);
endinterface

// ----- src/tle_out_if.sv -----
interface tle_out_if import tle_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [LAT_W-1:0] projected_latitude;
  logic signed [LON_W-1:0] projected_longitude;
  logic signed [ALT_W-1:0] projected_altitude_ft;
  logic                    sample_was_new;
  logic                    projection_applied;

  modport source (output valid, output projected_latitude, output projected_longitude,
                  output projected_altitude_ft, output sample_was_new,
                  output projection_applied, input ready);
  modport sink (input valid, input projected_latitude, input projected_longitude,
                input projected_altitude_ft, input sample_was_new,
                input projection_applied, output ready);
endinterface

// ----- src/tle_ctrl.sv -----
module tle_ctrl import tle_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  state_t               state;
  state_t               state_next;
  logic [DIV_CNT_W-1:0] div_cnt;
  comp_t                comp;
  comp_t                comp_succ;

  always_comb begin
    unique case (comp)
      COMP_LAT: comp_succ = COMP_LON;
      COMP_LON: comp_succ = COMP_ALT;
      default:  comp_succ = COMP_LAT;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_valid) state_next = ST_PREP;
      ST_PREP: state_next = status.proj_ok ? ST_DIV : ST_DIFF;
      ST_DIV:  if (div_cnt == DIV_LAST) state_next = ST_DIFF;
      ST_DIFF: state_next = ST_MUL;
      ST_MUL:  state_next = ST_STEP;
      ST_STEP: state_next = ST_ADD;
      ST_ADD:  state_next = (comp == COMP_ALT) ? ST_OUT : ST_DIFF;
      ST_OUT:  if (!status.out_busy) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.comp = comp;
    unique case (state)
      ST_IDLE: cmd.accept   = 1'b1;
      ST_PREP: cmd.prep     = 1'b1;
      ST_DIV:  cmd.div_step = 1'b1;
      ST_DIFF: cmd.diff     = 1'b1;
      ST_MUL:  cmd.mul      = 1'b1;
      ST_STEP: cmd.step     = 1'b1;
      ST_ADD:  cmd.add      = 1'b1;
      ST_OUT:  cmd.out_load = !status.out_busy;
      default: cmd.accept   = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      div_cnt <= '0;
      comp    <= COMP_LAT;
    end else begin
      state <= state_next;
      if (state == ST_PREP) begin
        div_cnt <= '0;
        comp    <= COMP_LAT;
      end else begin
        if (state == ST_DIV) div_cnt <= div_cnt + 1'b1;
        if (state == ST_ADD) comp <= comp_succ;
      end
    end
  end

endmodule

// ----- src/tle_dp.sv -----
module tle_dp import tle_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  ctrl_cmd_t   cmd,
  output dp_status_t  status,
  tle_cfg_if.sink     cfg,
  tle_in_if.sink      sample,
  tle_out_if.source   result
);

  logic [CFG_W-1:0] max_ext;

  logic signed [POS_W-1:0] newest_lat, newest_lon, older_lat, older_lon;
  logic signed [ALT_W-1:0] newest_alt, older_alt;
  logic [TIME_BITS-1:0]    newest_time, older_time, now_time;
  logic                    newest_valid, older_valid;
  logic                    is_new_r;

  logic [TIME_BITS-1:0] rem;
  logic [QUOT_W-1:0]    quot;
  logic [MAG_W-1:0]     mag;
  logic                 neg;
  logic [PROD_W-1:0]    prod;
  logic [STEP_W-1:0]    step;

  logic signed [LAT_W-1:0] res_lat;
  logic signed [LON_W-1:0] res_lon;
  logic signed [ALT_W-1:0] res_alt;

  logic                    fire;
  logic signed [POS_W-1:0] in_lat, in_lon;
  logic                    is_new;
  logic [TIME_BITS-1:0]    delta, since;
  logic [CFG_W-1:0]        ext;
  logic [TIME_BITS:0]      rem_sh, rem_sub;
  logic signed [POS_W-1:0] cur, old;
  logic signed [POS_W:0]   diff;
  logic [RND_W-1:0]        step_rnd;
  logic signed [SUM_W-1:0] cur_ext, step_s, sum, lo, hi, sat;

  assign cfg.ready    = 1'b1;
  assign sample.ready = cmd.accept;
  assign fire         = sample.valid && cmd.accept;

  assign in_lat = POS_W'(sample.latitude);
  assign in_lon = POS_W'(sample.longitude);
  assign is_new = !newest_valid || in_lat != newest_lat || in_lon != newest_lon
               || sample.altitude_ft != newest_alt;

  assign delta = newest_time - older_time;
  assign since = now_time - newest_time;
  assign ext   = (since < TIME_BITS'(max_ext)) ? since[CFG_W-1:0] : max_ext;

  assign status.proj_ok  = older_valid && (delta != '0);
  assign status.out_busy = result.valid && !result.ready;

  // restoring divider, one quotient bit per beat of the step command
  assign rem_sh  = {rem, quot[QUOT_W-1]};
  assign rem_sub = rem_sh - {1'b0, delta};

  always_comb begin
    case (cmd.comp)
      COMP_LAT: begin
        cur = newest_lat;
        old = older_lat;
        lo  = LAT_MIN;
        hi  = LAT_MAX;
      end
      COMP_LON: begin
        cur = newest_lon;
        old = older_lon;
        lo  = LON_MIN;
        hi  = LON_MAX;
      end
      default: begin
        cur = POS_W'(newest_alt);
        old = POS_W'(older_alt);
        lo  = ALT_MIN;
        hi  = ALT_MAX;
      end
    endcase
  end

  assign diff     = (POS_W + 1)'(cur) - (POS_W + 1)'(old);
  // round half away from zero on the magnitude
  assign step_rnd = {1'b0, prod[PROD_W-1:FRAC_BITS]} + RND_W'(prod[FRAC_BITS-1]);

  assign cur_ext = SUM_W'(cur);
  assign step_s  = $signed({1'b0, step});
  assign sum     = neg ? cur_ext - step_s : cur_ext + step_s;
  assign sat     = (sum < lo) ? lo : ((sum > hi) ? hi : sum);

  always_ff @(posedge clk) begin
    if (rst) begin
      max_ext      <= MAX_EXT_RESET;
      newest_valid <= 1'b0;
      older_valid  <= 1'b0;
      result.valid <= 1'b0;
    end else begin
      if (cfg.valid) max_ext <= cfg.data;
      if (fire && is_new) begin
        newest_valid <= 1'b1;
        if (newest_valid) older_valid <= 1'b1;
      end
      if (cmd.out_load) result.valid <= 1'b1;
      else if (result.ready) result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      now_time <= sample.sample_time_ms;
      is_new_r <= is_new;
      if (is_new) begin
        older_lat   <= newest_lat;
        older_lon   <= newest_lon;
        older_alt   <= newest_alt;
        older_time  <= newest_time;
        newest_lat  <= in_lat;
        newest_lon  <= in_lon;
        newest_alt  <= sample.altitude_ft;
        newest_time <= sample.sample_time_ms;
      end
    end

    if (cmd.prep) begin
      rem  <= '0;
      quot <= {ext, {FRAC_BITS{1'b0}}};
    end else if (cmd.div_step) begin
      if (!rem_sub[TIME_BITS]) begin
        rem  <= rem_sub[TIME_BITS-1:0];
        quot <= {quot[QUOT_W-2:0], 1'b1};
      end else begin
        rem  <= rem_sh[TIME_BITS-1:0];
        quot <= {quot[QUOT_W-2:0], 1'b0};
      end
    end

    if (cmd.diff) begin
      neg <= diff[POS_W];
      mag <= diff[POS_W] ? MAG_W'(-diff) : MAG_W'(diff);
    end

    if (cmd.mul) prod <= mag * quot;

    if (cmd.step) begin
      if (!status.proj_ok) step <= '0;
      else if (step_rnd > RND_W'(STEP_CLAMP)) step <= STEP_CLAMP;
      else step <= step_rnd[STEP_W-1:0];
    end

    if (cmd.add) begin
      case (cmd.comp)
        COMP_LAT: res_lat <= sat[LAT_W-1:0];
        COMP_LON: res_lon <= sat[LON_W-1:0];
        default:  res_alt <= sat[ALT_W-1:0];
      endcase
    end

    if (cmd.out_load) begin
      result.projected_latitude    <= res_lat;
      result.projected_longitude   <= res_lon;
      result.projected_altitude_ft <= res_alt;
      result.sample_was_new        <= is_new_r;
      result.projection_applied    <= status.proj_ok;
    end
  end

endmodule

// ----- src/track_linear_extrapolator.sv -----
// An accepted report passes through PREP, the serial divider (DIV, skipped when no
// projection applies), then DIFF, MUL, STEP and ADD for each component, and OUT.
// No new report is taken until the last one has left OUT, which waits while the output
// is stalled; the serial divider, one quotient bit per cycle, is the longest part.
// A finished result waits in the output register while the next report is taken.
// Reset (rst, synchronous) clears both samples and sets the limit to 10000 ms.
module track_linear_extrapolator import tle_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  tle_cfg_if.sink   cfg,
  tle_in_if.sink    sample,
  tle_out_if.source result
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  tle_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (sample.valid),
    .status   (status),
    .cmd      (cmd)
  );

  tle_dp u_dp (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .status (status),
    .cfg    (cfg),
    .sample (sample),
    .result (result)
  );

endmodule

// ----- src/tle_checker.sv -----
module tle_checker import tle_pkg::*; (
  input logic                    clk,
  input logic                    rst,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic signed [LAT_W-1:0] out_lat,
  input logic signed [LON_W-1:0] out_lon,
  input logic signed [ALT_W-1:0] out_alt,
  input logic                    out_new,
  input logic                    out_applied
);

  logic [1:0] pending;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 2'(in_valid && in_ready) - 2'(out_valid && out_ready);
    end
  end

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_lat) && $stable(out_lon)
      && $stable(out_alt) && $stable(out_new) && $stable(out_applied))
    else $error("result beat changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("report taken while another is in work");

  a_pending_max: assert property (@(posedge clk) disable iff (rst)
    pending != 2'd3)
    else $error("more than two reports outstanding");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> pending != 2'd0)
    else $error("result without an accepted report");

endmodule

bind track_linear_extrapolator tle_checker u_tle_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (sample.valid),
  .in_ready    (sample.ready),
  .out_valid   (result.valid),
  .out_ready   (result.ready),
  .out_lat     (result.projected_latitude),
  .out_lon     (result.projected_longitude),
  .out_alt     (result.projected_altitude_ft),
  .out_new     (result.sample_was_new),
  .out_applied (result.projection_applied)
);

// ----- tb/tb_track_linear_extrapolator.sv -----
module tb_track_linear_extrapolator;
  import tle_pkg::*;

  localparam int WATCHDOG_CYCLES = 4000;
  localparam int PHASE_ITEMS     = 325;
  localparam int NUM_PHASES      = 6;

  typedef struct {
    logic [TIME_BITS-1:0]    stamp;
    logic signed [LAT_W-1:0] lat;
    logic signed [LON_W-1:0] lon;
    logic signed [ALT_W-1:0] alt;
  } report_t;

  typedef struct {
    logic signed [LAT_W-1:0] lat;
    logic signed [LON_W-1:0] lon;
    logic signed [ALT_W-1:0] alt;
    logic                    fresh;
    logic                    applied;
  } fix_t;

  typedef struct {
    bit               is_cfg;
    logic [CFG_W-1:0] limit;
    report_t          rpt;
    bit               typed;
    fix_t             want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst;

  always #5 clk = ~clk;

  tle_cfg_if cfg_ch ();
  tle_in_if  rpt_ch ();
  tle_out_if fix_ch ();

  track_linear_extrapolator dut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_ch),
    .sample (rpt_ch),
    .result (fix_ch)
  );

  // track state as the block should hold it
  logic [CFG_W-1:0]     max_ext  = MAX_EXT_RESET;
  longint               trk_nlat = 0, trk_nlon = 0, trk_nalt = 0;
  logic [TIME_BITS-1:0] trk_nt   = '0;
  bit                   trk_nv   = 0;
  longint               trk_olat = 0, trk_olon = 0, trk_oalt = 0;
  logic [TIME_BITS-1:0] trk_ot   = '0;
  bit                   trk_ov   = 0;

  fix_t expected_fixes[$];

  int errors      = 0;
  int sent        = 0;
  int directed    = 0;
  int checked     = 0;
  int projected   = 0;
  int held        = 0;
  int cfg_writes  = 0;
  int burst_left  = 0;
  int idle_cycles = 0;

  plan_row_t plan[$];

  function automatic longint clip_to(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // one component: newest + round(diff * factor / 2^FRAC), halves away from zero, step clamped
  function automatic longint extrapolate(longint cur, longint old, logic [63:0] factor);
    longint       d;
    logic [63:0]  mag, p64, stp;
    logic [127:0] prod;
    d    = cur - old;
    mag  = (d < 0) ? 64'(-d) : 64'(d);
    prod = 128'(mag) * 128'(factor);
    p64  = (prod[127:64] != '0) ? '1 : prod[63:0];
    stp  = (p64 >> FRAC_BITS) + 64'(p64[FRAC_BITS-1]);
    if (stp > 64'(STEP_CLAMP)) stp = 64'(STEP_CLAMP);
    return (d < 0) ? cur - longint'(stp) : cur + longint'(stp);
  endfunction

  function automatic fix_t advance_track(report_t r);
    longint               lat, lon, alt, plat, plon, palt;
    logic [TIME_BITS-1:0] delta, since, ext;
    logic [63:0]          factor;
    fix_t                 f;
    lat = longint'(r.lat);
    lon = longint'(r.lon);
    alt = longint'(r.alt);
    f.fresh = !trk_nv || lat != trk_nlat || lon != trk_nlon || alt != trk_nalt;
    if (f.fresh) begin
      if (trk_nv) begin
        trk_olat = trk_nlat;
        trk_olon = trk_nlon;
        trk_oalt = trk_nalt;
        trk_ot   = trk_nt;
        trk_ov   = 1;
      end
      trk_nlat = lat;
      trk_nlon = lon;
      trk_nalt = alt;
      trk_nt   = r.stamp;
      trk_nv   = 1;
    end
    plat = trk_nlat;
    plon = trk_nlon;
    palt = trk_nalt;
    f.applied = 1'b0;
    if (trk_ov) begin
      delta = trk_nt - trk_ot;
      if (delta != '0) begin
        since  = r.stamp - trk_nt;
        ext    = (since < TIME_BITS'(max_ext)) ? since : TIME_BITS'(max_ext);
        factor = (64'(ext) << FRAC_BITS) / 64'(delta);
        plat   = extrapolate(trk_nlat, trk_olat, factor);
        plon   = extrapolate(trk_nlon, trk_olon, factor);
        palt   = extrapolate(trk_nalt, trk_oalt, factor);
        f.applied = 1'b1;
      end
    end
    f.lat = LAT_W'(clip_to(plat, longint'(LAT_MIN), longint'(LAT_MAX)));
    f.lon = LON_W'(clip_to(plon, longint'(LON_MIN), longint'(LON_MAX)));
    f.alt = ALT_W'(clip_to(palt, longint'(ALT_MIN), longint'(ALT_MAX)));
    return f;
  endfunction

  function automatic report_t mk_report(longint stamp, longint lat, longint lon, longint alt);
    report_t r;
    r.stamp = TIME_BITS'(stamp);
    r.lat   = LAT_W'(lat);
    r.lon   = LON_W'(lon);
    r.alt   = ALT_W'(alt);
    return r;
  endfunction

  function automatic plan_row_t rpt_row(report_t r);
    plan_row_t p;
    p.is_cfg = 0;
    p.limit  = '0;
    p.rpt    = r;
    p.typed  = 0;
    return p;
  endfunction

  function automatic plan_row_t want_row(report_t r, longint wlat, longint wlon,
                                         longint walt, bit fresh, bit applied);
    plan_row_t p;
    p.is_cfg       = 0;
    p.limit        = '0;
    p.rpt          = r;
    p.typed        = 1;
    p.want.lat     = LAT_W'(wlat);
    p.want.lon     = LON_W'(wlon);
    p.want.alt     = ALT_W'(walt);
    p.want.fresh   = fresh;
    p.want.applied = applied;
    return p;
  endfunction

  function automatic plan_row_t cfg_row(int v);
    plan_row_t p;
    p.is_cfg = 1;
    p.limit  = CFG_W'(v);
    p.typed  = 0;
    return p;
  endfunction

  task automatic note_error(string msg);
    if (errors < 50) $display("ERROR @%0t: %s", $time, msg);
    errors++;
  endtask

  task automatic cmp_field(string name, logic signed [63:0] got, logic signed [63:0] want);
    if (got !== want) note_error($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  // entered and left on a falling edge
  task automatic send_report(report_t r, bit typed, fix_t want);
    fix_t f;
    rpt_ch.valid          <= 1'b1;
    rpt_ch.sample_time_ms <= r.stamp;
    rpt_ch.latitude       <= r.lat;
    rpt_ch.longitude      <= r.lon;
    rpt_ch.altitude_ft    <= r.alt;
    do @(posedge clk); while (!rpt_ch.ready);
    f = advance_track(r);
    expected_fixes.push_back(typed ? want : f);
    sent++;
    @(negedge clk);
  endtask

  task automatic write_limit(logic [CFG_W-1:0] v);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    max_ext = v;
    cfg_writes++;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // hold off until every outstanding result has come back
  task automatic settle();
    rpt_ch.valid <= 1'b0;
    do @(negedge clk); while (expected_fixes.size() != 0);
  endtask

  task automatic sender_gap();
    int g, r;
    r = $urandom_range(0, 99);
    g = 0;
    if (burst_left > 0) burst_left--;
    else if (r < 4) burst_left = $urandom_range(20, 80);
    else if (r < 45) g = 0;
    else if (r < 92) g = $urandom_range(1, 5);
    else g = $urandom_range(20, 120);
    if (g > 0) begin
      rpt_ch.valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
  endtask

  // result side back-pressure
  initial begin
    int r, run, stall;
    @(negedge clk);
    forever begin
      r   = $urandom_range(0, 99);
      run = (r < 15) ? $urandom_range(100, 600) : $urandom_range(1, 12);
      fix_ch.ready <= 1'b1;
      repeat (run) @(negedge clk);
      r     = $urandom_range(0, 99);
      stall = (r < 40) ? 0 : ((r < 92) ? $urandom_range(1, 6) : $urandom_range(20, 150));
      if (stall > 0) begin
        fix_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    fix_t want;
    if (!rst && fix_ch.valid && fix_ch.ready) begin
      if (expected_fixes.size() == 0) begin
        note_error("result beat with nothing expected");
      end else begin
        want = expected_fixes.pop_front();
        checked++;
        if (want.applied) projected++;
        if (!want.fresh) held++;
        cmp_field("projected_latitude", fix_ch.projected_latitude, want.lat);
        cmp_field("projected_longitude", fix_ch.projected_longitude, want.lon);
        cmp_field("projected_altitude_ft", fix_ch.projected_altitude_ft, want.alt);
        cmp_field("sample_was_new", fix_ch.sample_was_new, want.fresh);
        cmp_field("projection_applied", fix_ch.projection_applied, want.applied);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (rpt_ch.valid && rpt_ch.ready) || (fix_ch.valid && fix_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_CYCLES) begin
      $display("watchdog: no beat for %0d cycles, %0d results outstanding",
               idle_cycles, expected_fixes.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int       ph, i, k, sub;
    int       phase_lim[NUM_PHASES];
    longint   tk_lat, tk_lon, tk_alt;
    logic [TIME_BITS-1:0] tk_t, dt;
    report_t  r;
    fix_t     none;

    rst                   = 1'b1;
    cfg_ch.valid          = 1'b0;
    cfg_ch.data           = '0;
    rpt_ch.valid          = 1'b0;
    rpt_ch.sample_time_ms = '0;
    rpt_ch.latitude       = '0;
    rpt_ch.longitude      = '0;
    rpt_ch.altitude_ft    = '0;
    fix_ch.ready          = 1'b0;
    none                  = '{default: '0};

    plan = {
      // first report after reset, then a repeat with no older sample
      want_row(mk_report(1000, 0, 0, 0), 0, 0, 0, 1, 0),
      want_row(mk_report(2000, 0, 0, 0), 0, 0, 0, 0, 0),
      // zero elapsed time, then doubling past the range limits
      want_row(mk_report(2000, 900000000, 1800000000, 100000),
               900000000, 1800000000, 100000, 1, 1),
      want_row(mk_report(3000, 900000000, 1800000000, 100000),
               900000000, 1800000000, 100000, 0, 1),
      want_row(mk_report(3000, -900000000, -1800000000, -2000),
               -900000000, -1800000000, -2000, 1, 1),
      // equal sample times, raw values beyond the field ranges
      want_row(mk_report(3000, -1073741824, -64'sd2147483648, -131072),
               -900000000, -1800000000, -2000, 1, 0),
      want_row(mk_report(3000, 1073741823, 2147483647, 131071),
               900000000, 1800000000, 100000, 1, 0),
      want_row(mk_report(3000, 1073741823, 2147483647, 131071),
               900000000, 1800000000, 100000, 0, 0),
      cfg_row(65535),
      want_row(mk_report(100, -900000000, -1800000000, -2000),
               -900000000, -1800000000, -2000, 1, 1),
      want_row(mk_report(101, 900000000, 1800000000, 100000),
               900000000, 1800000000, 100000, 1, 1),
      // step clamp: full-scale swing over 1 ms, max limit
      want_row(mk_report(70101, 900000000, 1800000000, 100000),
               900000000, 1800000000, 100000, 0, 1),
      // time stamp wraps
      want_row(mk_report(64'hFFFF_FFF0, 100, -100, 10), 100, -100, 10, 1, 1),
      want_row(mk_report(64'h10, 200, -200, 20), 200, -200, 20, 1, 1),
      want_row(mk_report(64'h30, 200, -200, 20), 300, -300, 30, 0, 1),
      cfg_row(0),
      want_row(mk_report(64'h1000, 200, -200, 20), 200, -200, 20, 0, 1),
      cfg_row(10000),
      rpt_row(mk_report(5000, 0, 0, 0)),
      want_row(mk_report(5002, 1, -1, 3), 1, -1, 3, 1, 1),
      // half-step rounding away from zero
      want_row(mk_report(5003, 1, -1, 3), 2, -2, 5, 0, 1),
      rpt_row(mk_report(25004, 1, -1, 3)),
      rpt_row(mk_report(25100, 123456789, -987654321, 35000)),
      rpt_row(mk_report(26000, 123456789, -987654321, 35000)),
      rpt_row(mk_report(26000, 123456000, -987650000, 34990)),
      rpt_row(mk_report(26777, 123456000, -987650000, 34990)),
      cfg_row(10000)
    };

    phase_lim = '{2000, 65535, 0, 0, 1, 10000};
    phase_lim[3] = $urandom_range(2, 65534);

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (plan[n]) begin
      if (plan[n].is_cfg) begin
        settle();
        write_limit(plan[n].limit);
      end else begin
        send_report(plan[n].rpt, plan[n].typed, plan[n].want);
        directed++;
        sender_gap();
      end
    end

    tk_lat = 473000000;
    tk_lon = -1220000000;
    tk_alt = 12000;
    tk_t   = 32'd40000;
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      settle();
      write_limit(CFG_W'(phase_lim[ph]));
      for (i = 0; i < PHASE_ITEMS; i++) begin
        k = $urandom_range(0, 99);
        if (k < 8) begin
          r = mk_report($urandom, $urandom, $urandom, $urandom);
        end else begin
          sub = $urandom_range(0, 99);
          if (sub < 5) dt = '0;
          else if (sub < 10) dt = $urandom;
          else if (sub < 20) dt = $urandom_range(10001, 70000);
          else dt = $urandom_range(1, 5000);
          tk_t += dt;
          sub = $urandom_range(0, 99);
          if (sub < 5) begin
            // jump near or past the range limits
            tk_lat = longint'($urandom_range(0, 2000000000)) - 1000000000;
            tk_lon = longint'($urandom_range(0, 32'd4200000000)) - 2100000000;
            tk_alt = longint'($urandom_range(0, 262143)) - 131072;
          end else if (sub >= 40) begin
            tk_lat = clip_to(tk_lat + longint'($urandom_range(0, 200000)) - 100000,
                             -1073741824, 1073741823);
            tk_lon = clip_to(tk_lon + longint'($urandom_range(0, 200000)) - 100000,
                             -64'sd2147483648, 2147483647);
            tk_alt = clip_to(tk_alt + longint'($urandom_range(0, 1000)) - 500,
                             -131072, 131071);
          end
          r = mk_report(tk_t, tk_lat, tk_lon, tk_alt);
        end
        send_report(r, 0, none);
        if ($urandom_range(0, 199) == 0) settle();
        else sender_gap();
      end
    end

    settle();
    repeat (60) @(posedge clk);

    $display("Ran %0d reports (%0d directed) over %0d limit settings incl. 0 and 65535",
             sent, directed, cfg_writes);
    $display("Checked %0d results: %0d projected, %0d with the latest sample kept",
             checked, projected, held);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
